/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the draw engine checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define MFDE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Property checked at every clock edge, reset included.
`define MFDE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/mfde_pkg.sv */
// ----------------------------------------------------------------------------
// mfde_pkg
// Types and constants of the monochrome framebuffer draw engine.
// ----------------------------------------------------------------------------
package mfde_pkg;

  localparam int WIDTH_DEF  = 128;
  localparam int HEIGHT_DEF = 64;
  localparam int BYTES_DEF  = 1024;

  // item field widths
  localparam int REQ_W   = 4;
  localparam int COORD_W = 10;
  localparam int BIDX_W  = 10;
  localparam int DATA_W  = 8;

  // internal math widths (cover the full parameter ranges)
  localparam int CW  = 12;  // signed coordinates, room for y+1 and y-1
  localparam int AXW = 16;  // signed byte address math

  typedef enum logic [REQ_W-1:0] {
    REQ_SET_PIXEL  = 4'd0,
    REQ_CLR_PIXEL  = 4'd1,
    REQ_BOX        = 4'd2,
    REQ_INVERT     = 4'd3,
    REQ_FRAME      = 4'd4,
    REQ_CLEAR_ALL  = 4'd5,
    REQ_WRITE_BYTE = 4'd6,
    REQ_READ_BYTE  = 4'd7,
    REQ_SWIPE_UP   = 4'd8,
    REQ_SWIPE_DOWN = 4'd9
  } req_type_t;

  // write-back stage operation
  typedef enum logic [2:0] {
    OP_NONE,
    OP_SET,
    OP_CLR,
    OP_TGL,
    OP_COPY,
    OP_WRITE,
    OP_READ
  } s2_op_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_RECT_SETUP,
    ST_RECT,
    ST_SWIPE,
    ST_BYTE,
    ST_DONE
  } state_t;

endpackage

/* rtl/mfde_req_if.sv */
// ----------------------------------------------------------------------------
// mfde_req_if
// Request channel: valid/ready handshake with one draw request per item.
// ----------------------------------------------------------------------------
interface mfde_req_if;
  logic                              valid;
  logic                              ready;
  logic [mfde_pkg::REQ_W-1:0]        req_type;
  logic signed [mfde_pkg::COORD_W-1:0] x_first;
  logic signed [mfde_pkg::COORD_W-1:0] y_first;
  logic signed [mfde_pkg::COORD_W-1:0] x_second;
  logic signed [mfde_pkg::COORD_W-1:0] y_second;
  logic                              fill_value;
  logic [mfde_pkg::BIDX_W-1:0]       byte_index;
  logic [mfde_pkg::DATA_W-1:0]       byte_value;

  modport source (
    output valid, req_type, x_first, y_first, x_second, y_second,
           fill_value, byte_index, byte_value,
    input  ready
  );
  modport sink (
    input  valid, req_type, x_first, y_first, x_second, y_second,
           fill_value, byte_index, byte_value,
    output ready
  );
endinterface

/* rtl/mfde_res_if.sv */
// ----------------------------------------------------------------------------
// mfde_res_if
// Result channel: valid/ready handshake with one result per item.
// ----------------------------------------------------------------------------
interface mfde_res_if;
  logic                        valid;
  logic                        ready;
  logic [mfde_pkg::DATA_W-1:0] read_data;
  logic                        status;

  modport source (output valid, read_data, status, input ready);
  modport sink (input valid, read_data, status, output ready);
endinterface

/* rtl/mono_framebuffer_draw_engine.sv */
// ----------------------------------------------------------------------------
// mono_framebuffer_draw_engine
// Page-organized monochrome framebuffer with pixel, rectangle, byte, clear and swipe ops.
// ----------------------------------------------------------------------------
// Box and invert run as one rectangle pass over the touched bytes; a frame
// runs up to four such passes; clear-all and swipe visit every byte of the
// store. One item in flight at a time, each stored byte going through the
// one-read/one-write memory on its own access.
// Reset: synchronous, active low; afterwards the store is swept to zero with
// the input held not-ready.
// ----------------------------------------------------------------------------
module mono_framebuffer_draw_engine #(
  parameter int WIDTH  = mfde_pkg::WIDTH_DEF,
  parameter int HEIGHT = mfde_pkg::HEIGHT_DEF,
  parameter int BYTES  = mfde_pkg::BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  mfde_req_if.sink          in_req,
  mfde_res_if.source        out_res,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data
);

  localparam int AW    = (BYTES > 1) ? $clog2(BYTES) : 1;
  localparam int CW    = mfde_pkg::CW;
  localparam int AXW   = mfde_pkg::AXW;
  localparam int PGW   = CW - 3;
  localparam int PAGES = HEIGHT / 8;
  localparam int NCOL  = (WIDTH / 4) * 4;   // columns that move on a swipe

  localparam logic signed [CW-1:0]  X_MAX     = CW'(WIDTH - 1);
  localparam logic signed [CW-1:0]  Y_MAX     = CW'(HEIGHT - 1);
  localparam logic signed [AXW-1:0] BYTES_S   = AXW'(BYTES);
  localparam logic signed [AXW-1:0] WIDTH_S   = AXW'(WIDTH);
  localparam logic signed [AXW-1:0] MARK_BASE = AXW'(BYTES - WIDTH);

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  mfde_pkg::state_t state_r, state_nxt;
  logic [1:0]       phase_r, phase_nxt;      // frame outline pass
  logic             st_r, st_nxt;            // result status
  logic signed [CW-1:0] xb_r, xb_nxt;
  logic signed [CW-1:0] ya_r, ya_nxt, yb_r, yb_nxt;
  logic signed [CW-1:0] cur_x_r, cur_x_nxt;
  logic [PGW-1:0]   cur_pg_r, cur_pg_nxt;
  logic [AW-1:0]    cnt_r, cnt_nxt;          // clear sweep address
  logic [PGW-1:0]   sw_pg_r, sw_pg_nxt;
  logic [CW-1:0]    sw_c_r, sw_c_nxt;
  logic             dbg_r;

  // latched request payload
  logic [mfde_pkg::REQ_W-1:0] req_r;
  logic signed [CW-1:0] x1_r, y1_r, x2_r, y2_r;
  logic [mfde_pkg::BIDX_W-1:0] bidx_r;
  logic [7:0]       bval_r;
  mfde_pkg::s2_op_t mode_r;
  logic             frame_r;

  // write-back stage
  mfde_pkg::s2_op_t s2_op_r;
  logic [AW-1:0]    s2_addr_r;
  logic [7:0]       s2_mask_r;
  logic [7:0]       s2_data_r;

  // frame store
  logic [7:0]       mem [BYTES];
  logic [7:0]       rdata_r;

  logic             out_valid_r;
  logic [7:0]       out_data_r;
  logic             out_status_r;

  // --------------------------------------------------------------------------
  // Input decode
  // --------------------------------------------------------------------------
  logic             in_acc;
  logic signed [CW-1:0] x1_in, y1_in, x2_in, y2_in;
  logic signed [AXW-1:0] pix_addr;
  logic             pix_ok;
  logic             inv_bad;

  assign in_req.ready = (state_r == mfde_pkg::ST_IDLE);
  assign in_acc       = in_req.valid && in_req.ready;

  assign x1_in = CW'(in_req.x_first);
  assign y1_in = CW'(in_req.y_first);
  assign x2_in = CW'(in_req.x_second);
  assign y2_in = CW'(in_req.y_second);

  // single-pixel target must be on screen and inside the store
  assign pix_addr = BYTES_S - AXW'(1) - AXW'(x1_in)
                    - AXW'(y1_in >>> 3) * WIDTH_S;
  assign pix_ok   = (x1_in >= 0) && (y1_in >= 0) && (x1_in <= X_MAX)
                    && (y1_in <= Y_MAX) && (pix_addr >= 0);
  assign inv_bad  = (x1_in > X_MAX) || (y1_in > Y_MAX)
                    || (x2_in > X_MAX) || (y2_in > Y_MAX);

  // --------------------------------------------------------------------------
  // Rectangle pass geometry; a frame is two rows and two columns
  // --------------------------------------------------------------------------
  logic signed [CW-1:0] rl, rh, rt, rb;
  logic signed [CW-1:0] cxa, cxb, cya, cyb;
  logic             rect_empty, last_phase;

  always_comb begin
    rl = x1_r;
    rh = x2_r;
    rt = y1_r;
    rb = y2_r;
    if (frame_r) begin
      case (phase_r)
        2'd0: begin rb = y1_r; end
        2'd1: begin rt = y2_r; end
        2'd2: begin rh = x1_r; rt = y1_r + CW'(1); rb = y2_r - CW'(1); end
        default: begin rl = x2_r; rt = y1_r + CW'(1); rb = y2_r - CW'(1); end
      endcase
    end
    cxa = (rl < 0) ? '0 : rl;
    cxb = (rh > X_MAX) ? X_MAX : rh;
    cya = (rt < 0) ? '0 : rt;
    cyb = (rb > Y_MAX) ? Y_MAX : rb;
    rect_empty = (cxa > cxb) || (cya > cyb);
    last_phase = !frame_r || (phase_r == 2'd3);
  end

  // byte address and bit mask of the current column/page
  logic signed [AXW-1:0] rect_addr;
  logic [PGW-1:0]   pg_lo, pg_hi;
  logic [2:0]       row_lo, row_hi;
  logic [7:0]       rect_mask;

  assign rect_addr = BYTES_S - AXW'(1) - AXW'(cur_x_r)
                     - $signed(AXW'(cur_pg_r)) * WIDTH_S;
  assign pg_lo  = ya_r[CW-1:3];
  assign pg_hi  = yb_r[CW-1:3];
  assign row_lo = (cur_pg_r == pg_lo) ? ya_r[2:0] : 3'd0;
  assign row_hi = (cur_pg_r == pg_hi) ? yb_r[2:0] : 3'd7;

  // row r of a page sits at bit 7-r
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      rect_mask[b] = (3'(7 - b) >= row_lo) && (3'(7 - b) <= row_hi);
    end
  end

  // swipe destination and source
  logic signed [AXW-1:0] sw_dst, sw_src;
  logic             sw_up;

  assign sw_up  = (req_r == mfde_pkg::REQ_SWIPE_UP);
  assign sw_dst = $signed(AXW'(sw_pg_r)) * WIDTH_S + $signed(AXW'(sw_c_r));
  assign sw_src = sw_up ? sw_dst - AXW'(4) : sw_dst + AXW'(4);

  // corner marker: top rows of the last five columns of page 0
  logic signed [AXW-1:0] mark_k;
  logic [7:0]       mark_mask;

  assign mark_k    = $signed(AXW'(bidx_r)) - MARK_BASE;
  assign mark_mask = (mark_k >= 0 && mark_k <= AXW'(4))
                     ? (8'hFF << (3 + mark_k[2:0])) : 8'h00;

  // --------------------------------------------------------------------------
  // Sequencer: issues at most one memory access per cycle
  // --------------------------------------------------------------------------
  mfde_pkg::s2_op_t iss_op;
  logic [AW-1:0]    iss_waddr, iss_raddr;
  logic             iss_re;
  logic [7:0]       iss_mask, iss_data;
  logic             out_load;

  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    st_nxt     = st_r;
    xb_nxt     = xb_r;
    ya_nxt     = ya_r;
    yb_nxt     = yb_r;
    cur_x_nxt  = cur_x_r;
    cur_pg_nxt = cur_pg_r;
    cnt_nxt    = cnt_r;
    sw_pg_nxt  = sw_pg_r;
    sw_c_nxt   = sw_c_r;
    iss_op     = mfde_pkg::OP_NONE;
    iss_waddr  = '0;
    iss_raddr  = '0;
    iss_re     = 1'b0;
    iss_mask   = '0;
    iss_data   = '0;
    out_load   = 1'b0;

    case (state_r)
      mfde_pkg::ST_INIT, mfde_pkg::ST_CLEAR: begin
        iss_op    = mfde_pkg::OP_WRITE;
        iss_waddr = cnt_r;
        if (cnt_r == AW'(BYTES - 1)) begin
          cnt_nxt   = '0;
          state_nxt = (state_r == mfde_pkg::ST_INIT) ? mfde_pkg::ST_IDLE
                                                      : mfde_pkg::ST_DONE;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end

      mfde_pkg::ST_IDLE: begin
        if (in_acc) begin
          st_nxt    = 1'b0;
          phase_nxt = 2'd0;
          case (mfde_pkg::req_type_t'(in_req.req_type))
            mfde_pkg::REQ_SET_PIXEL, mfde_pkg::REQ_CLR_PIXEL: begin
              st_nxt    = !pix_ok;
              state_nxt = mfde_pkg::ST_RECT_SETUP;
            end
            mfde_pkg::REQ_BOX, mfde_pkg::REQ_FRAME: begin
              state_nxt = mfde_pkg::ST_RECT_SETUP;
            end
            mfde_pkg::REQ_INVERT: begin
              st_nxt    = inv_bad;
              state_nxt = inv_bad ? mfde_pkg::ST_DONE : mfde_pkg::ST_RECT_SETUP;
            end
            mfde_pkg::REQ_CLEAR_ALL: begin
              cnt_nxt   = '0;
              state_nxt = mfde_pkg::ST_CLEAR;
            end
            mfde_pkg::REQ_WRITE_BYTE, mfde_pkg::REQ_READ_BYTE: begin
              if (AXW'(in_req.byte_index) >= AXW'(BYTES)) begin
                st_nxt    = 1'b1;
                state_nxt = mfde_pkg::ST_DONE;
              end else begin
                state_nxt = mfde_pkg::ST_BYTE;
              end
            end
            mfde_pkg::REQ_SWIPE_UP, mfde_pkg::REQ_SWIPE_DOWN: begin
              sw_pg_nxt = '0;
              sw_c_nxt  = (in_req.req_type == mfde_pkg::REQ_SWIPE_UP)
                          ? CW'(WIDTH - 1) : '0;
              state_nxt = mfde_pkg::ST_SWIPE;
            end
            default: begin
              st_nxt    = 1'b1;
              state_nxt = mfde_pkg::ST_DONE;
            end
          endcase
        end
      end

      mfde_pkg::ST_RECT_SETUP: begin
        // this idle state also lets the last write of a pass land
        if (rect_empty) begin
          if (last_phase) state_nxt = mfde_pkg::ST_DONE;
          else            phase_nxt = phase_r + 2'd1;
        end else begin
          xb_nxt     = cxb;
          ya_nxt     = cya;
          yb_nxt     = cyb;
          cur_x_nxt  = cxa;
          cur_pg_nxt = cya[CW-1:3];
          state_nxt  = mfde_pkg::ST_RECT;
        end
      end

      mfde_pkg::ST_RECT: begin
        if (rect_addr >= 0) begin
          iss_op    = mode_r;
          iss_re    = 1'b1;
          iss_raddr = rect_addr[AW-1:0];
          iss_waddr = rect_addr[AW-1:0];
          iss_mask  = rect_mask;
        end
        if (cur_pg_r == pg_hi) begin
          cur_pg_nxt = pg_lo;
          if (cur_x_r == xb_r) begin
            if (last_phase) begin
              state_nxt = mfde_pkg::ST_DONE;
            end else begin
              phase_nxt = phase_r + 2'd1;
              state_nxt = mfde_pkg::ST_RECT_SETUP;
            end
          end else begin
            cur_x_nxt = cur_x_r + CW'(1);
          end
        end else begin
          cur_pg_nxt = cur_pg_r + PGW'(1);
        end
      end

      mfde_pkg::ST_SWIPE: begin
        if (sw_dst < BYTES_S) begin
          iss_waddr = sw_dst[AW-1:0];
          if (sw_up ? (sw_c_r >= CW'(NCOL)) :
                      (sw_c_r + CW'(4) >= CW'(NCOL) && sw_c_r < CW'(WIDTH - 4))) begin
            iss_op = mfde_pkg::OP_NONE;          // column outside the moved span
          end else if ((sw_up ? (sw_c_r >= CW'(4)) : (sw_c_r + CW'(4) < CW'(NCOL)))
                       && (sw_src < BYTES_S)) begin
            iss_op    = mfde_pkg::OP_COPY;
            iss_re    = 1'b1;
            iss_raddr = sw_src[AW-1:0];
          end else begin
            iss_op = mfde_pkg::OP_WRITE;         // vacated column or source off store
          end
        end
        if (sw_up ? (sw_c_r == '0) : (sw_c_r == CW'(WIDTH - 1))) begin
          sw_c_nxt = sw_up ? CW'(WIDTH - 1) : '0;
          if (sw_pg_r == PGW'(PAGES - 1)) state_nxt = mfde_pkg::ST_DONE;
          else                            sw_pg_nxt = sw_pg_r + PGW'(1);
        end else begin
          sw_c_nxt = sw_up ? sw_c_r - CW'(1) : sw_c_r + CW'(1);
        end
      end

      mfde_pkg::ST_BYTE: begin
        iss_waddr = AW'(bidx_r);
        iss_raddr = AW'(bidx_r);
        iss_data  = bval_r;
        if (req_r == mfde_pkg::REQ_READ_BYTE) begin
          iss_op = mfde_pkg::OP_READ;
          iss_re = 1'b1;
        end else begin
          iss_op = mfde_pkg::OP_WRITE;
        end
        state_nxt = mfde_pkg::ST_DONE;
      end

      mfde_pkg::ST_DONE: begin
        // the result register may still hold the previous item
        if (!out_valid_r || out_res.ready) begin
          out_load  = 1'b1;
          state_nxt = mfde_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = mfde_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= mfde_pkg::ST_INIT;
      phase_r  <= '0;
      st_r     <= 1'b0;
      cnt_r    <= '0;
      sw_pg_r  <= '0;
      sw_c_r   <= '0;
      cur_x_r  <= '0;
      cur_pg_r <= '0;
      dbg_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      phase_r  <= phase_nxt;
      st_r     <= st_nxt;
      cnt_r    <= cnt_nxt;
      sw_pg_r  <= sw_pg_nxt;
      sw_c_r   <= sw_c_nxt;
      cur_x_r  <= cur_x_nxt;
      cur_pg_r <= cur_pg_nxt;
      if (cfg_wr_en) dbg_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    xb_r <= xb_nxt;
    ya_r <= ya_nxt;
    yb_r <= yb_nxt;
    if (in_acc) begin
      req_r   <= in_req.req_type;
      x1_r    <= x1_in;
      y1_r    <= y1_in;
      // a single pixel runs as a one-by-one rectangle
      x2_r    <= (in_req.req_type == mfde_pkg::REQ_SET_PIXEL ||
                  in_req.req_type == mfde_pkg::REQ_CLR_PIXEL) ? x1_in : x2_in;
      y2_r    <= (in_req.req_type == mfde_pkg::REQ_SET_PIXEL ||
                  in_req.req_type == mfde_pkg::REQ_CLR_PIXEL) ? y1_in : y2_in;
      bidx_r  <= in_req.byte_index;
      bval_r  <= in_req.byte_value;
      frame_r <= (in_req.req_type == mfde_pkg::REQ_FRAME);
      case (mfde_pkg::req_type_t'(in_req.req_type))
        mfde_pkg::REQ_CLR_PIXEL: mode_r <= mfde_pkg::OP_CLR;
        mfde_pkg::REQ_BOX:       mode_r <= in_req.fill_value ? mfde_pkg::OP_SET
                                                             : mfde_pkg::OP_CLR;
        mfde_pkg::REQ_INVERT:    mode_r <= mfde_pkg::OP_TGL;
        default:                 mode_r <= mfde_pkg::OP_SET;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Read-modify-write: the read is registered in rdata_r, then the s2_* write-back stage applies the op.
  // Back-to-back accesses never hit the same byte (each pass visits a byte
  // once, passes are separated by the setup state), so no forwarding path.
  // --------------------------------------------------------------------------
  logic             mem_we;
  logic [7:0]       mem_wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) s2_op_r <= mfde_pkg::OP_NONE;
    else        s2_op_r <= iss_op;
  end

  always_ff @(posedge clk) begin
    s2_addr_r <= iss_waddr;
    s2_mask_r <= iss_mask;
    s2_data_r <= iss_data;
  end

  always_comb begin
    mem_we    = 1'b1;
    mem_wdata = rdata_r;
    case (s2_op_r)
      mfde_pkg::OP_SET:   mem_wdata = rdata_r | s2_mask_r;
      mfde_pkg::OP_CLR:   mem_wdata = rdata_r & ~s2_mask_r;
      mfde_pkg::OP_TGL:   mem_wdata = rdata_r ^ s2_mask_r;
      mfde_pkg::OP_COPY:  mem_wdata = rdata_r;
      mfde_pkg::OP_WRITE: mem_wdata = s2_data_r;
      default:            mem_we    = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[s2_addr_r] <= mem_wdata;
    if (iss_re) rdata_r <= mem[iss_raddr];
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= st_r;
      out_data_r   <= (req_r == mfde_pkg::REQ_READ_BYTE && !st_r)
                      ? (rdata_r ^ (dbg_r ? mark_mask : 8'h00)) : 8'h00;
    end
  end

  assign out_res.valid     = out_valid_r;
  assign out_res.read_data = out_data_r;
  assign out_res.status    = out_status_r;

endmodule

/* rtl/mfde_checker.sv */
// ----------------------------------------------------------------------------
// mfde_checker
// Port-level checks of the draw engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mfde_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_read_data,
  input logic       out_status
);

  `MFDE_ASSERT_ALWAYS(a_busy_after_reset, clk, !rst_n |=> !in_ready, "ready right after reset")
  `MFDE_ASSERT(a_one_item, clk, rst_n, in_valid && in_ready |=> !in_ready, "second item taken")
  `MFDE_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result dropped")
  `MFDE_ASSERT(a_out_stable, clk, rst_n, out_valid && !out_ready |=> $stable(out_read_data) && $stable(out_status), "result changed")
  `MFDE_ASSERT(a_reject_zero, clk, rst_n, out_valid && out_status |-> out_read_data == 8'h00, "data on reject")

endmodule

bind mono_framebuffer_draw_engine mfde_checker u_mfde_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_req.valid),
  .in_ready      (in_req.ready),
  .out_valid     (out_res.valid),
  .out_ready     (out_res.ready),
  .out_read_data (out_res.read_data),
  .out_status    (out_res.status)
);

/* dv/tb_mono_framebuffer_draw_engine.sv */
// ----------------------------------------------------------------------------
// tb_mono_framebuffer_draw_engine
// Self-checking bench for the page framebuffer draw engine. A shadow copy of
// the frame store predicts every result the table does not fix. A short
// directed table comes first, then random requests in phases that toggle the
// debug marker. Both handshakes see random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_mono_framebuffer_draw_engine;

  localparam int REQ_W   = mfde_pkg::REQ_W;
  localparam int COORD_W = mfde_pkg::COORD_W;
  localparam int BIDX_W  = mfde_pkg::BIDX_W;
  localparam int DATA_W  = mfde_pkg::DATA_W;

  localparam int SCR_W     = mfde_pkg::WIDTH_DEF;
  localparam int SCR_H     = mfde_pkg::HEIGHT_DEF;
  localparam int STORE_LEN = mfde_pkg::BYTES_DEF;
  localparam int SIDX_W    = $clog2(STORE_LEN);
  localparam int IDLE_LIMIT = 40000;  // cycles with no item accepted on either side
  localparam int RAND_ITEMS = 580;

  // pixel update modes of the shadow store
  localparam int PAINT_CLR = 0;
  localparam int PAINT_SET = 1;
  localparam int PAINT_TGL = 2;

  // request codes outside the defined set
  localparam logic [REQ_W-1:0] REQ_UNUSED_LO = 4'd10;
  localparam logic [REQ_W-1:0] REQ_UNUSED_HI = 4'd15;

  typedef struct {
    logic [REQ_W-1:0]          kind;
    logic signed [COORD_W-1:0] x1, y1, x2, y2;
    logic                      fill;
    logic [BIDX_W-1:0]         idx;
    logic [DATA_W-1:0]         val;
    bit                        fixed;   // expected result typed in the table
    logic [DATA_W-1:0]         fix_data;
    logic                      fix_status;
  } draw_req_t;

  typedef struct {
    logic [DATA_W-1:0] data;
    logic              status;
  } draw_result_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic cfg_wr_data;

  mfde_req_if req_ch ();
  mfde_res_if res_ch ();

  mono_framebuffer_draw_engine dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_req      (req_ch),
    .out_res     (res_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // shadow frame store and marker setting
  logic [DATA_W-1:0] shadow_frame [STORE_LEN];
  bit                marker_on;

  draw_req_t    req_backlog[$];     // requests waiting to be offered
  draw_result_t awaited_results[$];
  int           mismatch_cnt;
  int           idle_cycles;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Shadow store
  // --------------------------------------------------------------------------
  function automatic bit paint_pixel(int x, int y, int mode);
    int a;
    logic [DATA_W-1:0] b;
    if (x < 0 || y < 0 || x >= SCR_W || y >= SCR_H) return 1'b0;
    a = STORE_LEN - 1 - x - (y / 8) * SCR_W;
    if (a < 0 || a >= STORE_LEN) return 1'b0;
    b = 8'h80 >> (y % 8);
    case (mode)
      PAINT_SET: shadow_frame[SIDX_W'(a)] |= b;
      PAINT_CLR: shadow_frame[SIDX_W'(a)] &= ~b;
      default:   shadow_frame[SIDX_W'(a)] ^= b;
    endcase
    return 1'b1;
  endfunction

  // corner triangle: pixels (W-5+r .. W-1, r) for r = 0..4, all in page 0
  function automatic logic [DATA_W-1:0] corner_marker(int idx);
    logic [DATA_W-1:0] m;
    m = '0;
    for (int r = 0; r < 5; r++)
      for (int x = SCR_W - 5 + r; x < SCR_W; x++)
        if (STORE_LEN - 1 - x - (r / 8) * SCR_W == idx) m ^= 8'h80 >> (r % 8);
    return m;
  endfunction

  function automatic void shift_pages(bit toward_high);
    int n, row;
    n = (SCR_W / 4) * 4;
    for (int j = 0; j < SCR_H / 8; j++) begin
      row = j * SCR_W;
      if (toward_high) begin
        for (int c = n - 1; c >= 4; c--)
          shadow_frame[SIDX_W'(row + c)] = shadow_frame[SIDX_W'(row + c - 4)];
        for (int c = 0; c < 4; c++) shadow_frame[SIDX_W'(row + c)] = '0;
      end else begin
        for (int c = 0; c + 4 < n; c++)
          shadow_frame[SIDX_W'(row + c)] = shadow_frame[SIDX_W'(row + c + 4)];
        for (int c = SCR_W - 4; c < SCR_W; c++) shadow_frame[SIDX_W'(row + c)] = '0;
      end
    end
  endfunction

  // applies one request to the shadow store and returns its result
  function automatic draw_result_t apply_draw(draw_req_t r);
    draw_result_t res;
    int x1, y1, x2, y2, xa, xb, ya, yb;
    bit dummy;
    x1 = r.x1; y1 = r.y1; x2 = r.x2; y2 = r.y2;
    res.data = '0;
    res.status = 1'b0;
    case (r.kind)
      mfde_pkg::REQ_SET_PIXEL: res.status = !paint_pixel(x1, y1, PAINT_SET);
      mfde_pkg::REQ_CLR_PIXEL: res.status = !paint_pixel(x1, y1, PAINT_CLR);
      mfde_pkg::REQ_BOX: begin
        xa = (x1 > 0) ? x1 : 0;
        xb = (x2 < SCR_W - 1) ? x2 : SCR_W - 1;
        ya = (y1 > 0) ? y1 : 0;
        yb = (y2 < SCR_H - 1) ? y2 : SCR_H - 1;
        for (int x = xa; x <= xb; x++)
          for (int y = ya; y <= yb; y++)
            dummy = paint_pixel(x, y, r.fill ? PAINT_SET : PAINT_CLR);
      end
      mfde_pkg::REQ_INVERT: begin
        // any coordinate at or past its bound rejects the whole request
        if (x1 >= SCR_W || y1 >= SCR_H || x2 >= SCR_W || y2 >= SCR_H) begin
          res.status = 1'b1;
        end else begin
          xa = (x1 > 0) ? x1 : 0;
          ya = (y1 > 0) ? y1 : 0;
          for (int x = xa; x <= x2; x++)
            for (int y = ya; y <= y2; y++) dummy = paint_pixel(x, y, PAINT_TGL);
        end
      end
      mfde_pkg::REQ_FRAME: begin
        xa = (x1 > 0) ? x1 : 0;
        xb = (x2 < SCR_W - 1) ? x2 : SCR_W - 1;
        for (int x = xa; x <= xb; x++) begin
          dummy = paint_pixel(x, y1, PAINT_SET);
          dummy = paint_pixel(x, y2, PAINT_SET);
        end
        ya = (y1 + 1 > 0) ? y1 + 1 : 0;
        yb = (y2 - 1 < SCR_H - 1) ? y2 - 1 : SCR_H - 1;
        for (int y = ya; y <= yb; y++) begin
          dummy = paint_pixel(x1, y, PAINT_SET);
          dummy = paint_pixel(x2, y, PAINT_SET);
        end
      end
      mfde_pkg::REQ_CLEAR_ALL: foreach (shadow_frame[i]) shadow_frame[i] = '0;
      mfde_pkg::REQ_WRITE_BYTE: begin
        if (r.idx < STORE_LEN) shadow_frame[r.idx] = r.val;
        else res.status = 1'b1;
      end
      mfde_pkg::REQ_READ_BYTE: begin
        if (r.idx < STORE_LEN) begin
          res.data = shadow_frame[r.idx];
          if (marker_on) res.data ^= corner_marker(r.idx);
        end else begin
          res.status = 1'b1;
        end
      end
      mfde_pkg::REQ_SWIPE_UP:   shift_pages(1'b1);
      mfde_pkg::REQ_SWIPE_DOWN: shift_pages(1'b0);
      default:                  res.status = 1'b1;
    endcase
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus builders
  // --------------------------------------------------------------------------
  function automatic draw_req_t draw_row(logic [REQ_W-1:0] kind, int x1, int y1, int x2,
                                         int y2, bit fill, int idx, int val);
    draw_req_t r;
    r.kind = kind;
    r.x1 = COORD_W'(x1); r.y1 = COORD_W'(y1);
    r.x2 = COORD_W'(x2); r.y2 = COORD_W'(y2);
    r.fill = fill;
    r.idx = BIDX_W'(idx);
    r.val = DATA_W'(val);
    r.fixed = 1'b0;
    r.fix_data = '0;
    r.fix_status = 1'b0;
    return r;
  endfunction

  function automatic draw_req_t known_row(draw_req_t r, int data, bit status);
    r.fixed = 1'b1;
    r.fix_data = DATA_W'(data);
    r.fix_status = status;
    return r;
  endfunction

  // mostly near the screen, sometimes anywhere in the field
  function automatic int pick_coord(int bound);
    if ($urandom_range(0, 9) == 0) return $signed(COORD_W'($urandom));
    return $urandom_range(0, bound + 7) - 4;
  endfunction

  function automatic draw_req_t random_draw();
    draw_req_t r;
    int pick;
    r = draw_row(mfde_pkg::REQ_READ_BYTE, pick_coord(SCR_W), pick_coord(SCR_H), 0, 0,
                 1'($urandom_range(0, 1)), $urandom_range(0, STORE_LEN - 1),
                 $urandom_range(0, 255));
    // mostly small rectangles, now and then a wild one
    if ($urandom_range(0, 9) == 0) begin
      r.x2 = COORD_W'(pick_coord(SCR_W));
      r.y2 = COORD_W'(pick_coord(SCR_H));
    end else begin
      r.x2 = COORD_W'(r.x1 + $urandom_range(0, 12) - 1);
      r.y2 = COORD_W'(r.y1 + $urandom_range(0, 12) - 1);
    end
    pick = $urandom_range(0, 99);
    if      (pick < 14) r.kind = mfde_pkg::REQ_SET_PIXEL;
    else if (pick < 24) r.kind = mfde_pkg::REQ_CLR_PIXEL;
    else if (pick < 36) r.kind = mfde_pkg::REQ_BOX;
    else if (pick < 46) r.kind = mfde_pkg::REQ_INVERT;
    else if (pick < 54) r.kind = mfde_pkg::REQ_FRAME;
    else if (pick < 56) r.kind = mfde_pkg::REQ_CLEAR_ALL;
    else if (pick < 72) r.kind = mfde_pkg::REQ_WRITE_BYTE;
    else if (pick < 93) r.kind = mfde_pkg::REQ_READ_BYTE;
    else if (pick < 95) r.kind = mfde_pkg::REQ_SWIPE_UP;
    else if (pick < 97) r.kind = mfde_pkg::REQ_SWIPE_DOWN;
    else                r.kind = REQ_W'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
    // reads of the last eight store bytes are worth hitting more often
    if (r.kind == mfde_pkg::REQ_READ_BYTE && $urandom_range(0, 3) == 0)
      r.idx = BIDX_W'(STORE_LEN - 1 - $urandom_range(0, 7));
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Request driver: bursts of random length, random gaps between them.
  // An offered item is held until accepted.
  // --------------------------------------------------------------------------
  int burst_left;
  int gap_left;

  always @(posedge clk) begin
    draw_req_t    cur;
    draw_result_t res;
    bit           taken;
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
      burst_left = $urandom_range(1, 12);
      gap_left = 0;
    end else begin
      taken = req_ch.valid && req_ch.ready;
      if (taken) begin
        cur = req_backlog.pop_front();
        res = apply_draw(cur);
        if (cur.fixed) begin
          res.data = cur.fix_data;
          res.status = cur.fix_status;
        end
        awaited_results.push_back(res);
      end
      if (req_ch.valid && !taken) begin
        // keep holding the same item
      end else if (gap_left > 0) begin
        gap_left--;
        req_ch.valid <= 1'b0;
      end else if (req_backlog.size() > 0) begin
        cur = req_backlog[0];
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= cur.kind;
        req_ch.x_first    <= cur.x1;
        req_ch.y_first    <= cur.y1;
        req_ch.x_second   <= cur.x2;
        req_ch.y_second   <= cur.y2;
        req_ch.fill_value <= cur.fill;
        req_ch.byte_index <= cur.idx;
        req_ch.byte_value <= cur.val;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result side: ready follows its own pattern (free run, coin flip, hard
  // stall), each for a random stretch.
  // --------------------------------------------------------------------------
  int stall_mode;
  int stall_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
      stall_mode = 0;
      stall_left = 0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_left = (stall_mode == 2) ? $urandom_range(1, 8) : $urandom_range(4, 40);
      end
      stall_left--;
      case (stall_mode)
        0:       res_ch.ready <= 1'b1;
        1:       res_ch.ready <= 1'($urandom_range(0, 1));
        default: res_ch.ready <= 1'b0;
      endcase
    end
  end

  // result checker, oldest expectation first
  always @(posedge clk) begin
    draw_result_t want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (awaited_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result item: read_data=%h status=%b",
                   res_ch.read_data, res_ch.status);
      end else begin
        want = awaited_results.pop_front();
        if (res_ch.read_data !== want.data || res_ch.status !== want.status) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("result mismatch: read_data exp %h got %h, status exp %b got %b",
                     want.data, res_ch.read_data, want.status, res_ch.status);
        end
      end
    end
  end

  // watchdog: no item accepted on either side for too long
  always @(posedge clk) begin
    if (!rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencing
  // --------------------------------------------------------------------------
  task automatic wait_drained();
    while (req_backlog.size() != 0 || awaited_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);  // last result out, block back in idle
  endtask

  task automatic set_marker(bit on);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= on;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    marker_on = on;
  endtask

  draw_req_t directed_tbl[$];

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.req_type = '0;
    req_ch.x_first = '0;
    req_ch.y_first = '0;
    req_ch.x_second = '0;
    req_ch.y_second = '0;
    req_ch.fill_value = 1'b0;
    req_ch.byte_index = '0;
    req_ch.byte_value = '0;
    res_ch.ready = 1'b0;
    mismatch_cnt = 0;
    idle_cycles = 0;
    marker_on = 1'b0;
    foreach (shadow_frame[i]) shadow_frame[i] = '0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    set_marker(1'b0);

    // store reads zero after reset; byte address extremes
    directed_tbl.push_back(known_row(draw_row(mfde_pkg::REQ_READ_BYTE,
                                              0, 0, 0, 0, 0, 0, 0), 0, 0));
    directed_tbl.push_back(known_row(draw_row(mfde_pkg::REQ_READ_BYTE,
                                              0, 0, 0, 0, 0, 1023, 0), 0, 0));
    directed_tbl.push_back(known_row(draw_row(mfde_pkg::REQ_WRITE_BYTE,
                                              0, 0, 0, 0, 0, 1023, 255), 0, 0));
    directed_tbl.push_back(known_row(draw_row(mfde_pkg::REQ_READ_BYTE,
                                              0, 0, 0, 0, 0, 1023, 0), 255, 0));
    directed_tbl.push_back(draw_row(mfde_pkg::REQ_WRITE_BYTE, 0, 0, 0, 0, 0, 0, 8'h5a));
    // pixel out of bounds on every side
    directed_tbl.push_back(known_row(draw_row(mfde_pkg::REQ_SET_PIXEL,
                                              -512, 0, 0, 0, 0, 0, 0), 0, 1));
    directed_tbl.push_back(known_row(draw_row(mfde_pkg::REQ_SET_PIXEL,
                                              511, 511, 0, 0, 0, 0, 0), 0, 1));
    directed_tbl.push_back(known_row(draw_row(mfde_pkg::REQ_CLR_PIXEL,
                                              0, -1, 0, 0, 0, 0, 0), 0, 1));
    directed_tbl.push_back(known_row(draw_row(mfde_pkg::REQ_SET_PIXEL,
                                              128, 63, 0, 0, 0, 0, 0), 0, 1));
    directed_tbl.push_back(draw_row(mfde_pkg::REQ_SET_PIXEL, 0, 0, 0, 0, 0, 0, 0));
    directed_tbl.push_back(draw_row(mfde_pkg::REQ_CLR_PIXEL, 127, 63, 0, 0, 0, 0, 0));
    // whole-field box, clipped to the screen
    directed_tbl.push_back(known_row(draw_row(mfde_pkg::REQ_BOX,
                                              -512, -512, 511, 511, 1, 0, 0), 0, 0));
    directed_tbl.push_back(draw_row(mfde_pkg::REQ_READ_BYTE, 0, 0, 0, 0, 0, 500, 0));
    // empty box range
    directed_tbl.push_back(known_row(draw_row(mfde_pkg::REQ_BOX,
                                              5, 5, 3, 3, 0, 0, 0), 0, 0));
    directed_tbl.push_back(draw_row(mfde_pkg::REQ_BOX, 3, 2, 70, 40, 0, 0, 0));
    // invert: past bound rejected, negative corner clipped
    directed_tbl.push_back(known_row(draw_row(mfde_pkg::REQ_INVERT,
                                              0, 0, 128, 10, 0, 0, 0), 0, 1));
    directed_tbl.push_back(known_row(draw_row(mfde_pkg::REQ_INVERT,
                                              0, 64, 10, 10, 0, 0, 0), 0, 1));
    directed_tbl.push_back(draw_row(mfde_pkg::REQ_INVERT, -5, -3, 10, 20, 0, 0, 0));
    // frames: huge and partly off screen
    directed_tbl.push_back(draw_row(mfde_pkg::REQ_FRAME, -512, -512, 511, 511, 0, 0, 0));
    directed_tbl.push_back(draw_row(mfde_pkg::REQ_FRAME, 10, 5, 140, 30, 0, 0, 0));
    directed_tbl.push_back(draw_row(mfde_pkg::REQ_SWIPE_UP, 0, 0, 0, 0, 0, 0, 0));
    directed_tbl.push_back(draw_row(mfde_pkg::REQ_SWIPE_DOWN, 0, 0, 0, 0, 0, 0, 0));
    directed_tbl.push_back(draw_row(mfde_pkg::REQ_READ_BYTE, 0, 0, 0, 0, 0, 3, 0));
    // unused request codes
    directed_tbl.push_back(known_row(draw_row(REQ_UNUSED_LO, 0, 0, 0, 0, 0, 0, 0), 0, 1));
    directed_tbl.push_back(known_row(draw_row(REQ_UNUSED_HI, 0, 0, 0, 0, 0, 0, 0), 0, 1));
    directed_tbl.push_back(known_row(draw_row(mfde_pkg::REQ_CLEAR_ALL,
                                              0, 0, 0, 0, 0, 0, 0), 0, 0));
    directed_tbl.push_back(known_row(draw_row(mfde_pkg::REQ_READ_BYTE,
                                              0, 0, 0, 0, 0, 1000, 0), 0, 0));

    foreach (directed_tbl[i]) req_backlog.push_back(directed_tbl[i]);
    wait_drained();

    // random phases, marker toggled between them
    for (int phase = 0; phase < 4; phase++) begin
      set_marker(phase % 2 == 0);
      for (int n = 0; n < RAND_ITEMS / 4; n++) req_backlog.push_back(random_draw());
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (mismatch_cnt == 0 && awaited_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
